@@ rtl/bra_pkg.sv @@
// Shared types, constants and codes for the bitmap run allocator.
package bra_pkg;

    localparam int MAP_BITS_DEF = 16384;
    localparam int SEG_BITS_DEF = 4096;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;

    // Datapath operation for the current cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_SEG_INIT,
        OP_SEG_NEXT,
        OP_CHECK_GO,
        OP_LOAD,
        OP_STEP,
        OP_SHORT,
        OP_MARK_INIT,
        OP_MARK_RD,
        OP_MARK_WR,
        OP_SINGLE_RD,
        OP_SINGLE_WR,
        OP_FAIL
    } op_t;

    // Outcome of examining one block during the scan.
    typedef enum logic [1:0] {
        EV_STEP,
        EV_SEG_END,
        EV_SHORT,
        EV_FOUND
    } scan_ev_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic     clr_last;
        logic     is_alloc;
        logic     is_single;
        logic     addr_ok;
        logic     pos_ge_re;
        logic     check_fail;
        scan_ev_t scan_ev;
        logic     step_cross;
        logic     mark_last;
    } status_t;

endpackage

@@ rtl/bra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bra_datapath.sv @@
// Datapath of the allocator: request registers, scan pointers, bitmap RAM and result.
module bra_datapath #(
    parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF,
    parameter int SEG_BITS = bra_pkg::SEG_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bra_pkg::cmd_t                      cmd,
    output bra_pkg::status_t                   status,
    input  logic [bra_pkg::IN_TDATA_W-1:0]     req_data,
    output logic [bra_pkg::OUT_TDATA_W-1:0]    res_data
);
    import bra_pkg::*;

    localparam int LG_MAP = $clog2(MAP_BITS);
    localparam int LG_SEG = $clog2(SEG_BITS);
    localparam int LG_MAX = (LG_MAP > LG_SEG) ? LG_MAP : LG_SEG;
    localparam int CW     = ((LG_MAX > 13) ? LG_MAX : 13) + 2;
    localparam int WORDS  = MAP_BITS / 32;
    localparam int WAW    = $clog2(WORDS);

    localparam logic [CW-1:0] MAP_C   = CW'(MAP_BITS);
    localparam logic [CW-1:0] SEG_C   = CW'(SEG_BITS);
    localparam logic [CW-1:0] SEG_MSK = CW'(SEG_BITS - 1);
    localparam logic [CW-1:0] WRD_MSK = CW'(31);
    localparam logic [CW-1:0] WRD_C   = CW'(32);

    logic [1:0]    act_reg, act_next;
    logic [13:0]   addr_reg, addr_next;
    logic [CW-1:0] re_reg, re_next;
    logic [CW-1:0] minl_reg, minl_next;
    logic [CW-1:0] maxl_reg, maxl_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] se_reg, se_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] e_reg, e_next;
    logic [CW-1:0] mb_reg, mb_next;
    logic          phase_reg, phase_next;
    logic [31:0]   word_reg, word_next;
    logic [WAW-1:0] clr_reg, clr_next;
    logic          found_reg, found_next;
    logic [13:0]   rstart_reg, rstart_next;
    logic [12:0]   rlen_reg, rlen_next;

    logic [1:0]    in_act;
    logic [CW-1:0] in_rs, in_re, in_minl, in_maxl;
    logic [13:0]   in_addr;
    logic [CW-1:0] seg_end, b_inc, se_calc, run_len, wbase, wbase_next;
    logic          cur_bit;
    logic [31:0]   mark_mask;
    logic [31:0]   rdata, wdata;
    logic          we;
    logic [WAW-1:0] waddr, raddr;

    // Request field unpacking.
    assign in_act  = req_data[1:0];
    assign in_rs   = CW'(req_data[15:2]);
    assign in_re   = CW'(req_data[30:16]);
    assign in_minl = CW'(req_data[43:31]);
    assign in_maxl = CW'(req_data[56:44]);
    assign in_addr = req_data[70:57];

    // Scan arithmetic.
    assign seg_end    = (pos_reg & ~SEG_MSK) + SEG_C;
    assign b_inc      = b_reg + CW'(1);
    assign se_calc    = b_reg + maxl_reg;
    assign run_len    = b_reg - s_reg;
    assign cur_bit    = word_reg[b_reg[4:0]];
    assign wbase      = mb_reg & ~WRD_MSK;
    assign wbase_next = wbase + WRD_C;

    // Mask of run blocks that fall in the word being marked.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            mark_mask[i] = (5'(i) >= mb_reg[4:0]) && ((wbase + CW'(i)) < e_reg);
        end
    end

    // Status towards the controller. A maximum below the minimum can never
    // yield a run, so every segment is passed over at once.
    always_comb
    begin
        status.clr_last   = (clr_reg == WAW'(WORDS - 1));
        status.is_alloc   = (act_reg == ACT_ALLOC);
        status.is_single  = (act_reg == ACT_FREE) || (act_reg == ACT_MARK);
        status.addr_ok    = (CW'(addr_reg) < MAP_C);
        status.pos_ge_re  = (pos_reg >= re_reg);
        status.check_fail = ((s_reg + minl_reg) > lim_reg) || (maxl_reg < minl_reg);
        status.step_cross = (b_reg[4:0] == 5'd31);
        status.mark_last  = (wbase_next >= e_reg);
        if (!phase_reg)
        begin
            status.scan_ev = (b_reg >= lim_reg) ? EV_SEG_END : EV_STEP;
        end
        else if ((b_reg >= se_reg) || cur_bit)
        begin
            status.scan_ev = (run_len >= minl_reg) ? EV_FOUND : EV_SHORT;
        end
        else
        begin
            status.scan_ev = EV_STEP;
        end
    end

    // RAM port selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = clr_reg;
        wdata = '0;
        raddr = s_reg[WAW+4:5];
        case (cmd.op)
            OP_CLR:
            begin
                we = 1'b1;
            end
            OP_STEP:
            begin
                raddr = b_inc[WAW+4:5];
            end
            OP_MARK_RD:
            begin
                raddr = mb_reg[WAW+4:5];
            end
            OP_MARK_WR:
            begin
                we    = 1'b1;
                waddr = mb_reg[WAW+4:5];
                wdata = rdata | mark_mask;
            end
            OP_SINGLE_RD:
            begin
                raddr = addr_reg[WAW+4:5];
            end
            OP_SINGLE_WR:
            begin
                we    = 1'b1;
                waddr = addr_reg[WAW+4:5];
                wdata = rdata;
                wdata[addr_reg[4:0]] = (act_reg == ACT_MARK);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    bra_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Next-state logic of the datapath registers.
    always_comb
    begin
        act_next    = act_reg;
        addr_next   = addr_reg;
        re_next     = re_reg;
        minl_next   = minl_reg;
        maxl_next   = maxl_reg;
        pos_next    = pos_reg;
        lim_next    = lim_reg;
        s_next      = s_reg;
        se_next     = se_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        mb_next     = mb_reg;
        phase_next  = phase_reg;
        word_next   = word_reg;
        clr_next    = clr_reg;
        found_next  = found_reg;
        rstart_next = rstart_reg;
        rlen_next   = rlen_reg;
        case (cmd.op)
            OP_CLR:
            begin
                clr_next = clr_reg + WAW'(1);
            end
            OP_LATCH:
            begin
                act_next  = in_act;
                addr_next = in_addr;
                re_next   = (in_re > MAP_C) ? MAP_C : in_re;
                minl_next = (in_minl == '0) ? CW'(1) : in_minl;
                maxl_next = in_maxl;
                pos_next  = in_rs;
            end
            OP_SEG_INIT:
            begin
                lim_next = (seg_end < re_reg) ? seg_end : re_reg;
                s_next   = pos_reg;
            end
            OP_SEG_NEXT:
            begin
                pos_next = seg_end;
            end
            OP_CHECK_GO:
            begin
                b_next     = s_reg;
                phase_next = 1'b0;
            end
            OP_LOAD:
            begin
                word_next = rdata;
            end
            OP_STEP:
            begin
                if (!phase_reg && !cur_bit)
                begin
                    s_next     = b_reg;
                    se_next    = (se_calc < lim_reg) ? se_calc : lim_reg;
                    phase_next = 1'b1;
                end
                b_next = b_inc;
            end
            OP_SHORT:
            begin
                s_next = b_inc;
            end
            OP_MARK_INIT:
            begin
                e_next      = b_reg;
                mb_next     = s_reg;
                found_next  = 1'b1;
                rstart_next = s_reg[13:0];
                rlen_next   = run_len[12:0];
            end
            OP_MARK_WR:
            begin
                mb_next = wbase_next;
            end
            OP_SINGLE_WR:
            begin
                found_next  = 1'b1;
                rstart_next = '0;
                rlen_next   = '0;
            end
            OP_FAIL:
            begin
                found_next  = 1'b0;
                rstart_next = '0;
                rlen_next   = '0;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Clear-pass counter is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        addr_reg   <= addr_next;
        re_reg     <= re_next;
        minl_reg   <= minl_next;
        maxl_reg   <= maxl_next;
        pos_reg    <= pos_next;
        lim_reg    <= lim_next;
        s_reg      <= s_next;
        se_reg     <= se_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        mb_reg     <= mb_next;
        phase_reg  <= phase_next;
        word_reg   <= word_next;
        found_reg  <= found_next;
        rstart_reg <= rstart_next;
        rlen_reg   <= rlen_next;
    end

    assign res_data = {4'd0, rlen_reg, rstart_reg, found_reg};

endmodule

@@ rtl/bra_ctrl.sv @@
// Controller state machine of the allocator.
module bra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bra_pkg::status_t status,
    output bra_pkg::cmd_t    cmd
);
    import bra_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR    = 12'b0000_0000_0001,
        ST_IDLE     = 12'b0000_0000_0010,
        ST_DISPATCH = 12'b0000_0000_0100,
        ST_SEG      = 12'b0000_0000_1000,
        ST_CHECK    = 12'b0000_0001_0000,
        ST_WAIT     = 12'b0000_0010_0000,
        ST_SCAN     = 12'b0000_0100_0000,
        ST_MRD      = 12'b0000_1000_0000,
        ST_MWR      = 12'b0001_0000_0000,
        ST_SRD      = 12'b0010_0000_0000,
        ST_SWR      = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);

    // Sequencing of the datapath operations.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_alloc)
                begin
                    state_next = ST_SEG;
                end
                else if (status.is_single && status.addr_ok)
                begin
                    state_next = ST_SRD;
                end
                else
                begin
                    cmd.op     = OP_FAIL;
                    state_next = ST_DONE;
                end
            end
            ST_SEG:
            begin
                if (status.pos_ge_re)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_SEG_INIT;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.check_fail)
                begin
                    cmd.op     = OP_SEG_NEXT;
                    state_next = ST_SEG;
                end
                else
                begin
                    cmd.op     = OP_CHECK_GO;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.op     = OP_LOAD;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                case (status.scan_ev)
                    EV_STEP:
                    begin
                        cmd.op = OP_STEP;
                        if (status.step_cross)
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    EV_SEG_END:
                    begin
                        cmd.op     = OP_SEG_NEXT;
                        state_next = ST_SEG;
                    end
                    EV_SHORT:
                    begin
                        cmd.op     = OP_SHORT;
                        state_next = ST_CHECK;
                    end
                    default:
                    begin
                        cmd.op     = OP_MARK_INIT;
                        state_next = ST_MRD;
                    end
                endcase
            end
            ST_MRD:
            begin
                cmd.op     = OP_MARK_RD;
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                cmd.op     = OP_MARK_WR;
                state_next = status.mark_last ? ST_DONE : ST_MRD;
            end
            ST_SRD:
            begin
                cmd.op     = OP_SINGLE_RD;
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                cmd.op     = OP_SINGLE_WR;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // The block never takes a request while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");

    // A pending result stays until taken.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped before it was taken");

    // Marking starts only from the scan.
    a_mark_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MARK_INIT) |-> (state_reg == ST_SCAN))
        else $error("marking started outside the scan");

    // A marking write of the map comes only after a read of that word.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWR) |-> ($past(state_reg) == ST_MRD))
        else $error("map word written without a preceding read");
`endif

endmodule

@@ rtl/bitmap_run_allocator_core.sv @@
// Top level of the bitmap run allocator: controller, datapath and stream ports.
//
// After reset the bitmap RAM is swept to zero, one 32-block word per cycle
// (MAP_BITS/32 words, 512 at the default size), and no request is taken
// until that pass ends. One request is handled at a time. Free and mark read
// and write one word. An allocation walks the range one block per cycle,
// halting to load each word it enters and at each segment and rejected run;
// a found run is then marked by a read and a write of every word it touches.
// The word-by-word scan over the bitmap RAM sets the rate.
module bitmap_run_allocator_core #(
    parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF,
    parameter int SEG_BITS = bra_pkg::SEG_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[1:0], range_start[15:2], range_end[30:16], min_len[43:31],
    // max_len[56:44], block_addr[70:57], zero pad[71]
    input  logic [bra_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found[0], run_start[14:1], run_length[27:15], zero pad[31:28]
    output logic [bra_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bra_pkg::*;

    cmd_t    cmd;
    status_t status;

    bra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bra_datapath #(
        .MAP_BITS (MAP_BITS),
        .SEG_BITS (SEG_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req_data (s_tdata),
        .res_data (m_tdata)
    );

endmodule
